FILE: rtl/disc_sector_to_hunk_lru_cache_macros.svh
// assertion macros for the hunk cache
`ifndef DISC_SECTOR_TO_HUNK_LRU_CACHE_MACROS_SVH
`define DISC_SECTOR_TO_HUNK_LRU_CACHE_MACROS_SVH

// plain implication checked on every clock edge outside reset
`define DSH_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// next-cycle implication
`define DSH_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: rtl/dsh_pkg.sv
package dsh_pkg;
	localparam int TRACK_SLOTS = 128;
	localparam int CACHE_WAYS  = 4;
	localparam int SLOT_W      = $clog2(TRACK_SLOTS);
	localparam int WAY_W       = (CACHE_WAYS > 1) ? $clog2(CACHE_WAYS) : 1;
	localparam int LBA_W       = 20;
	localparam int AGE_W       = 32;
	localparam int FPH_W       = 7;
	localparam int TCNT_W      = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;
	localparam int TRK_W       = 3 * LBA_W + 1;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_FAIL = 2'd2;

	localparam logic [2:0] ST_HIT     = 3'd0;
	localparam logic [2:0] ST_MISS    = 3'd1;
	localparam logic [2:0] ST_SILENCE = 3'd2;
	localparam logic [2:0] ST_ERROR   = 3'd3;
	localparam logic [2:0] ST_ACK     = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FPH    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TCNT   = 2'd2;

	typedef struct packed {
		logic [1:0]       op;
		logic [LBA_W-1:0] sector_lba;
		logic [6:0]       track_slot;
		logic [LBA_W-1:0] start_lba;
		logic [LBA_W-1:0] end_lba;
		logic [LBA_W-1:0] first_frame;
		logic             is_audio;
	} in_item_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [LBA_W-1:0] hunk_number;
		logic [1:0]       cache_way;
		logic [5:0]       hunk_frame;
		logic             swap_bytes;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic capture;   // latch input item
		logic load_trk;  // write track slot
		logic chk_trk;   // latch frame and audio flag from returned entry
		logic div_start;
		logic div_step;
		logic lookup;    // hit/miss update
		logic fail;      // invalidate last victim
		logic clr_scan;
		logic inc_scan;
		logic [2:0] set_status;
		logic set_out;   // write result register
	} dsh_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] op;
		logic       inactive;
		logic       scan_end;
		logic       trk_match;
		logic       div_done;
		logic       hit;
	} dsh_sts_t;
endpackage

FILE: rtl/disc_sector_to_hunk_lru_cache.sv
// Sector-to-hunk translator with a four-way LRU hunk tag directory.
// Input channel in_valid/in_ready carries one item: op 0 loads a track
// slot, op 1 reads a sector, op 2 drops the last filled way.
// Output channel out_valid/out_ready returns one result item per input.
// Config: cfg_we/cfg_idx/cfg_data write enable, frames per hunk and track
// count; write only while the block is idle.
// Loads and acks skip the scan. A read scans the track table one slot at
// a time, as it sits in a RAM with one read port, and hunk/frame come
// from a restoring divider giving one quotient bit a cycle.
// One item is in flight at a time; in_ready is high only when idle.
// If the receiver stalls the result holds on out_data until taken.
// Reset clears config, directory valid bits, ages and the age counter;
// the track table is undefined until loaded.
module disc_sector_to_hunk_lru_cache import dsh_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	dsh_cmd_t cmd;
	dsh_sts_t sts;

	dsh_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
	);

	dsh_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in_data(in_data), .cmd(cmd), .sts(sts),
		.out_data(out_data)
	);
endmodule

FILE: rtl/dsh_ram.sv
module dsh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/dsh_datapath.sv
module dsh_datapath import dsh_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  in_item_t              in_data,
	input  dsh_cmd_t              cmd,
	output dsh_sts_t              sts,
	output out_item_t             out_data
);
	logic             enable_q;
	logic [FPH_W-1:0] fph_q;
	logic [TCNT_W-1:0] tcnt_q;
	in_item_t         item_q;
	logic [TCNT_W:0]  scan_q;
	logic [TRK_W-1:0] trk_rd;
	logic [LBA_W-1:0] t_first, t_last, t_base;
	logic             t_audio;
	logic             audio_q;
	logic [LBA_W-1:0] rem_q, quo_q, dvd_q;
	logic [4:0]       dcnt_q;
	logic [LBA_W:0]   rem_sh;
	logic [LBA_W:0]   rem_sub;

	logic [CACHE_WAYS-1:0] valid_q;
	logic [LBA_W-1:0] tag_q [CACHE_WAYS];
	logic [AGE_W-1:0] age_q [CACHE_WAYS];
	logic [AGE_W-1:0] agec_q;
	logic [WAY_W-1:0] victim_q;
	logic [AGE_W-1:0] age_nx;
	logic             hit;
	logic [WAY_W-1:0] hit_way, vic;
	logic [AGE_W-1:0] vage, a;
	logic [TCNT_W:0]  limit;
	logic [SLOT_W-1:0] slot_in;
	out_item_t        out_nx;

	assign slot_in = item_q.track_slot[SLOT_W-1:0];

	dsh_ram #(.WIDTH(TRK_W), .DEPTH(TRACK_SLOTS)) u_trk (
		.clk  (clk),
		.we   (cmd.load_trk),
		.waddr(slot_in),
		.wdata({item_q.start_lba, item_q.end_lba, item_q.first_frame, item_q.is_audio}),
		.raddr(scan_q[SLOT_W-1:0]),
		.rdata(trk_rd)
	);
	assign {t_first, t_last, t_base, t_audio} = trk_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			fph_q    <= '0;
			tcnt_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_FPH:    fph_q    <= cfg_data[FPH_W-1:0];
				REG_TCNT:   tcnt_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign limit = (tcnt_q > TCNT_W'(TRACK_SLOTS)) ? (TCNT_W+1)'(TRACK_SLOTS)
	                                                : {1'b0, tcnt_q};

	// restoring divider, one quotient bit a cycle
	assign rem_sh  = {rem_q, dvd_q[LBA_W-1]};
	assign rem_sub = rem_sh - {{(LBA_W+1-FPH_W){1'b0}}, fph_q};

	always_comb begin
		hit = 1'b0;
		hit_way = '0;
		for (int i = CACHE_WAYS - 1; i >= 0; i--)
			if (valid_q[i] && tag_q[i] == quo_q) begin
				hit = 1'b1;
				hit_way = WAY_W'(i);
			end
		vic  = '0;
		vage = valid_q[0] ? age_q[0] : '0;
		for (int i = 1; i < CACHE_WAYS; i++) begin
			a = valid_q[i] ? age_q[i] : '0;
			if (a < vage) begin
				vic  = WAY_W'(i);
				vage = a;
			end
		end
	end
	assign age_nx = agec_q + AGE_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.capture)
			item_q <= in_data;
		if (cmd.chk_trk) begin
			dvd_q   <= t_base + (item_q.sector_lba - t_first);
			audio_q <= t_audio;
		end
		if (cmd.div_start) begin
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			if (!rem_sub[LBA_W]) rem_q <= rem_sub[LBA_W-1:0];
			else                 rem_q <= rem_sh[LBA_W-1:0];
			quo_q  <= {quo_q[LBA_W-2:0], ~rem_sub[LBA_W]};
			dvd_q  <= {dvd_q[LBA_W-2:0], 1'b0};
			dcnt_q <= dcnt_q + 5'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q   <= '0;
			valid_q  <= '0;
			agec_q   <= AGE_W'(1);
			victim_q <= '0;
			for (int i = 0; i < CACHE_WAYS; i++) begin
				tag_q[i] <= '1;
				age_q[i] <= '0;
			end
		end else begin
			if (cmd.clr_scan)      scan_q <= '0;
			else if (cmd.inc_scan) scan_q <= scan_q + (TCNT_W+1)'(1);
			if (cmd.lookup) begin
				agec_q <= age_nx;
				if (hit) begin
					age_q[hit_way] <= age_nx;
				end else begin
					valid_q[vic] <= 1'b1;
					tag_q[vic]   <= quo_q;
					age_q[vic]   <= age_nx;
					victim_q     <= vic;
				end
			end
			if (cmd.fail)
				valid_q[victim_q] <= 1'b0;
		end
	end

	always_comb begin
		out_nx = '0;
		out_nx.status = cmd.set_status;
		case (cmd.set_status)
			ST_HIT, ST_MISS: begin
				out_nx.hunk_number = quo_q;
				out_nx.cache_way   = 2'(cmd.set_status == ST_HIT ? hit_way : vic);
				out_nx.hunk_frame  = rem_q[5:0];
				out_nx.swap_bytes  = audio_q;
			end
			ST_ACK: begin
				if (item_q.op == OP_FAIL)
					out_nx.cache_way = 2'(victim_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.set_out)
			out_data <= out_nx;
	end

	assign sts.op        = item_q.op;
	assign sts.inactive  = !enable_q || fph_q == '0;
	assign sts.scan_end  = scan_q >= limit;
	assign sts.trk_match = item_q.sector_lba >= t_first && item_q.sector_lba < t_last;
	assign sts.div_done  = dcnt_q == 5'(LBA_W);
	assign sts.hit       = hit;
endmodule

FILE: rtl/dsh_ctrl.sv
module dsh_ctrl import dsh_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dsh_sts_t sts,
	output dsh_cmd_t cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_DECODE, S_RDREQ, S_RDWAIT, S_CHECK, S_DIV, S_LOOKUP, S_OUT
	} state_t;
	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE:
					if (in_valid) state_q <= S_DECODE;
				S_DECODE: begin
					if (sts.op == OP_READ && !sts.inactive) state_q <= S_RDREQ;
					else begin
						state_q <= S_OUT;
						out_valid <= 1'b1;
					end
				end
				S_RDREQ: begin
					if (sts.scan_end) begin
						state_q <= S_OUT;
						out_valid <= 1'b1;
					end else state_q <= S_RDWAIT;
				end
				S_RDWAIT: state_q <= S_CHECK;
				S_CHECK:
					if (sts.trk_match) state_q <= S_DIV;
					else               state_q <= S_RDREQ;
				S_DIV:
					if (sts.div_done) state_q <= S_LOOKUP;
				S_LOOKUP: begin
					state_q <= S_OUT;
					out_valid <= 1'b1;
				end
				S_OUT:
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q <= S_IDLE;
					end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.capture  = in_valid;
				cmd.clr_scan = 1'b1;
			end
			S_DECODE: begin
				cmd.set_out = !(sts.op == OP_READ && !sts.inactive);
				cmd.load_trk = sts.op == OP_LOAD;
				cmd.fail = sts.op == OP_FAIL;
				cmd.set_status = (sts.op == OP_READ) ? ST_ERROR : ST_ACK;
			end
			S_RDREQ: begin
				cmd.set_out = sts.scan_end;
				cmd.set_status = ST_SILENCE;
			end
			S_CHECK: begin
				cmd.chk_trk = 1'b1;
				cmd.div_start = 1'b1;
				cmd.inc_scan = !sts.trk_match;
			end
			S_DIV: cmd.div_step = !sts.div_done;
			S_LOOKUP: begin
				cmd.lookup = 1'b1;
				cmd.set_out = 1'b1;
				cmd.set_status = sts.hit ? ST_HIT : ST_MISS;
			end
			default: ;
		endcase
	end
endmodule

FILE: rtl/dsh_checker.sv
`include "disc_sector_to_hunk_lru_cache_macros.svh"
module dsh_checker import dsh_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);
	`DSH_ASSERT(a_one_inflight, clk, arst_n, !(in_ready && out_valid), "ready while result pending")
	`DSH_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")
	`DSH_ASSERT(a_status_range, clk, arst_n, !out_valid || out_data.status <= ST_ACK, "bad status")
	`DSH_ASSERT(a_silent_zero, clk, arst_n, !(out_valid && out_data.status == ST_SILENCE) || (out_data.hunk_number == '0 && !out_data.swap_bytes), "silence result not clear")
	`DSH_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_valid && in_ready, !in_ready, "accepted twice")
endmodule

bind disc_sector_to_hunk_lru_cache dsh_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

FILE: test/tb_top.sv
`timescale 1ns / 100ps

import dsh_pkg::*;

class hunk_scoreboard;
	logic [LBA_W-1:0] trk_first [TRACK_SLOTS];
	logic [LBA_W-1:0] trk_end [TRACK_SLOTS];
	logic [LBA_W-1:0] trk_base [TRACK_SLOTS];
	bit               trk_audio [TRACK_SLOTS];
	bit               way_valid [CACHE_WAYS];
	logic [LBA_W-1:0] way_tag [CACHE_WAYS];
	bit [AGE_W-1:0]   way_age [CACHE_WAYS];
	bit [AGE_W-1:0]   age_ctr;
	bit [1:0]         last_victim;
	bit               enable;
	bit [FPH_W-1:0]   fph;
	bit [TCNT_W-1:0]  tcnt;
	out_item_t        expected_q[$];
	int               mismatches;

	function new();
		for (int i = 0; i < CACHE_WAYS; i++) begin
			way_valid[i] = 0;
			way_tag[i] = '1;
			way_age[i] = 0;
		end
		age_ctr = 1;
		last_victim = 0;
		enable = 0;
		fph = 0;
		tcnt = 0;
		mismatches = 0;
	endfunction

	function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_ENABLE: enable = val[0];
			REG_FPH: fph = val[FPH_W-1:0];
			REG_TCNT: tcnt = val;
			default: ;
		endcase
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	function void note_input(in_item_t it);
		out_item_t r;
		int found, n, victim;
		bit [LBA_W-1:0] frame, hunk, fih;
		bit [AGE_W-1:0] a, vage;
		r = '0;
		r.status = ST_ACK;
		found = -1;
		if (it.op == OP_LOAD) begin
			trk_first[it.track_slot] = it.start_lba;
			trk_end[it.track_slot] = it.end_lba;
			trk_base[it.track_slot] = it.first_frame;
			trk_audio[it.track_slot] = it.is_audio;
		end else if (it.op == OP_FAIL) begin
			way_valid[last_victim] = 0;
			r.cache_way = last_victim;
		end else if (it.op == OP_READ) begin
			if (!enable || fph == 0) begin
				r.status = ST_ERROR;
			end else begin
				n = (tcnt < TRACK_SLOTS) ? tcnt : TRACK_SLOTS;
				for (int i = 0; i < n && found < 0; i++)
					if (it.sector_lba >= trk_first[i] && it.sector_lba < trk_end[i])
						found = i;
				if (found < 0) begin
					r.status = ST_SILENCE;
				end else begin
					frame = trk_base[found] + (it.sector_lba - trk_first[found]);
					hunk = frame / fph;
					fih = frame % fph;
					r.hunk_number = hunk;
					r.hunk_frame = fih[5:0];
					r.swap_bytes = trk_audio[found];
					victim = -1;
					for (int i = 0; i < CACHE_WAYS && victim < 0; i++)
						if (way_valid[i] && way_tag[i] == hunk)
							victim = i;
					age_ctr = age_ctr + 1;
					if (victim >= 0) begin
						r.status = ST_HIT;
					end else begin
						r.status = ST_MISS;
						victim = 0;
						vage = way_valid[0] ? way_age[0] : '0;
						for (int i = 1; i < CACHE_WAYS; i++) begin
							a = way_valid[i] ? way_age[i] : '0;
							if (a < vage) begin
								victim = i;
								vage = a;
							end
						end
						way_valid[victim] = 1;
						way_tag[victim] = hunk;
						last_victim = 2'(victim);
					end
					way_age[victim] = age_ctr;
					r.cache_way = 2'(victim);
				end
			end
		end
		expected_q.push_back(r);
	endfunction

	function void check_result(out_item_t got);
		out_item_t exp_r;
		if (expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result item %p", got);
			return;
		end
		exp_r = expected_q.pop_front();
		if (got.status !== exp_r.status || got.hunk_number !== exp_r.hunk_number ||
				got.cache_way !== exp_r.cache_way ||
				got.hunk_frame !== exp_r.hunk_frame ||
				got.swap_bytes !== exp_r.swap_bytes) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result mismatch: expected %p got %p", exp_r, got);
		end
	endfunction
endclass

module tb_top;
	localparam logic [1:0] OP_SPARE = 2'd3;

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  in_valid = 0;
	logic                  in_ready;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 0;
	out_item_t             out_data;
	logic                  cfg_we = 0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	hunk_scoreboard sb = new();
	int tx_pct = 0;
	int rx_pct = 0;
	bit hold_req = 0;
	int hold_left = 0;

	disc_sector_to_hunk_lru_cache dut (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);
		if (hold_req) begin
			hold_left = 400;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(0, 99) >= rx_pct);
	end

	initial begin
		#(80ms);
		$display("disc_sector_to_hunk_lru_cache verification failed");
		$finish;
	end

	task automatic send(in_item_t it);
		in_data <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_input(it);
		if ($urandom_range(0, 99) < tx_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < tx_pct);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic configure(bit en, int fph, int tcnt);
		drain();
		write_reg(REG_ENABLE, CFG_DATA_W'(en));
		write_reg(REG_FPH, CFG_DATA_W'(fph));
		write_reg(REG_TCNT, CFG_DATA_W'(tcnt));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic in_item_t track_load(int slot, bit wide);
		in_item_t it;
		int len;
		it = '0;
		it.op = OP_LOAD;
		it.track_slot = 7'(slot);
		it.sector_lba = LBA_W'($urandom);
		if (wide) begin
			it.start_lba = LBA_W'($urandom);
			it.end_lba = LBA_W'($urandom);
			it.first_frame = LBA_W'($urandom);
		end else begin
			len = $urandom_range(1, 300);
			it.start_lba = LBA_W'($urandom_range(0, 4000));
			it.end_lba = LBA_W'(it.start_lba + len);
			it.first_frame = ($urandom_range(0, 9) == 0)
				? LBA_W'(20'hFFFFF - $urandom_range(0, 200))
				: LBA_W'($urandom_range(0, 511));
		end
		it.is_audio = 1'($urandom);
		return it;
	endfunction

	function automatic in_item_t sector_read(logic [LBA_W-1:0] lba);
		in_item_t it;
		it = '0;
		it.op = OP_READ;
		it.sector_lba = lba;
		it.track_slot = 7'($urandom);
		return it;
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		int r, n, s;
		bit [LBA_W-1:0] span;
		r = $urandom_range(0, 99);
		n = (sb.tcnt < TRACK_SLOTS) ? sb.tcnt : TRACK_SLOTS;
		if (r < 70 && n > 0) begin
			s = $urandom_range(0, n - 1);
			span = sb.trk_end[s] - sb.trk_first[s];
			if (sb.trk_end[s] > sb.trk_first[s] && span <= 4096)
				it = sector_read(LBA_W'(sb.trk_first[s] + $urandom_range(0, span - 1)));
			else
				it = sector_read(LBA_W'($urandom_range(0, 4400)));
		end else if (r < 80) begin
			it = sector_read(LBA_W'($urandom));
		end else if (r < 90) begin
			it = track_load($urandom_range(0, TRACK_SLOTS - 1), $urandom_range(0, 3) == 0);
		end else if (r < 97) begin
			it = '0;
			it.op = OP_FAIL;
			it.sector_lba = LBA_W'($urandom);
		end else begin
			it = $urandom_range(0, 1) ? track_load(0, 1'b1) : sector_read(LBA_W'($urandom));
			it.op = OP_SPARE;
		end
		return it;
	endfunction

	initial begin
		in_item_t it;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(sector_read('0));
		it = '0;
		it.op = OP_FAIL;
		send(it);
		it.op = OP_SPARE;
		send(it);

		// fixed tracks: one-sector, frame wrap, empty, inverted
		it = '0;
		it.op = OP_LOAD;
		it.end_lba = 20'd1;
		send(it);
		it.track_slot = 7'd1;
		it.start_lba = 20'hFFF00;
		it.end_lba = 20'hFFFFF;
		it.first_frame = 20'hFFFF0;
		it.is_audio = 1'b1;
		send(it);
		it.track_slot = 7'd2;
		it.start_lba = 20'd5;
		it.end_lba = 20'd5;
		it.is_audio = 1'b0;
		send(it);
		it.track_slot = 7'd3;
		it.start_lba = 20'd100;
		it.end_lba = 20'd0;
		send(it);
		for (int s = 4; s < TRACK_SLOTS; s++)
			send(track_load(s, 1'b0));

		configure(1'b1, 0, TRACK_SLOTS);
		send(sector_read('0));
		configure(1'b1, 1, TRACK_SLOTS);
		send(sector_read('0));
		send(sector_read('0));
		send(sector_read(20'hFFFFE));
		send(sector_read(20'hFFFFF));
		it = '0;
		it.op = OP_FAIL;
		send(it);
		send(sector_read('0));
		configure(1'b1, 127, 255);
		send(sector_read(20'hFFFFE));
		send(sector_read(20'hFFF00));
		configure(1'b1, 64, 0);
		send(sector_read('0));

		for (int p = 0; p < 12; p++) begin
			case (p)
				0: configure(1'b1, 1, TRACK_SLOTS);
				1: configure(1'b1, 64, 200);
				2: configure(1'b1, 127, 16);
				3: configure(1'b0, 8, 40);
				default: configure($urandom_range(0, 9) != 0,
					($urandom_range(0, 9) == 0) ? 127 : $urandom_range(0, 64),
					$urandom_range(0, TRACK_SLOTS));
			endcase
			tx_pct = (p % 4 == 1) ? 63 : (p % 4 == 3) ? 33 : 0;
			rx_pct = (p % 4 == 2) ? 63 : (p % 4 == 3) ? 33 : 0;
			for (int k = 0; k < 150; k++) begin
				if (p == 1 && k == 20)
					hold_req = 1;
				send(random_item());
			end
		end

		drain();
		repeat (500) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("disc_sector_to_hunk_lru_cache verification clean");
		else
			$display("disc_sector_to_hunk_lru_cache verification failed");
		$finish;
	end
endmodule

FILE: files.f
+incdir+rtl
rtl/dsh_pkg.sv
rtl/dsh_ram.sv
rtl/dsh_datapath.sv
rtl/dsh_ctrl.sv
rtl/disc_sector_to_hunk_lru_cache.sv
rtl/dsh_checker.sv
test/tb_top.sv
